// File: design/i2cm_pkg.sv
package i2cm_pkg;

    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam int HBT_W = 10;
    localparam logic [HBT_W-1:0] HBT_RESET = 10'd5;

    localparam logic [2:0] PHASE_LAST_EDGE = 3'd2;
    localparam logic [3:0] ACK_BIT         = 4'd8;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [2:0]       phase;
        logic [3:0]       bit_idx;
        logic [HBT_W-1:0] tick;
        logic [7:0]       shift;
        logic             ack_wanted;
        logic             scl;
        logic             sda;
        logic             ack_seen;
        logic [7:0]       rx_hold;
    } state_t;

    localparam state_t STATE_RESET = '{
        cmd:        CMD_IDLE,
        phase:      3'd0,
        bit_idx:    4'd0,
        tick:       '0,
        shift:      8'd0,
        ack_wanted: 1'b0,
        scl:        1'b1,
        sda:        1'b0,
        ack_seen:   1'b0,
        rx_hold:    8'd0
    };

    typedef struct packed {
        logic       scl_high;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       slave_acked;
        logic       command_ignored;
    } result_t;

endpackage

// File: design/i2cm_step.sv
module i2cm_step (
    input  i2cm_pkg::state_t            cur,
    input  logic [2:0]                  operation,
    input  logic [7:0]                  tx_byte,
    input  logic                        send_ack,
    input  logic                        sda_level,
    input  logic [i2cm_pkg::HBT_W-1:0]  half_bit_ticks,
    output i2cm_pkg::state_t            nxt,
    output i2cm_pkg::result_t           res
);
    import i2cm_pkg::*;

    always_comb
    begin
        logic [HBT_W-1:0] slot_len;
        logic             slot_end;
        logic             is_cmd;
        logic             done;
        logic             ignored;

        nxt      = cur;
        done     = 1'b0;
        ignored  = 1'b0;
        slot_len = (half_bit_ticks == '0) ? HBT_W'(1) : half_bit_ticks;
        is_cmd   = (operation == CMD_START) || (operation == CMD_STOP) ||
                   (operation == CMD_WRITE) || (operation == CMD_READ);

        if (is_cmd)
        begin
            if (cur.cmd == CMD_IDLE)
            begin
                nxt.cmd        = operation;
                nxt.phase      = 3'd0;
                nxt.bit_idx    = 4'd0;
                nxt.tick       = '0;
                nxt.shift      = (operation == CMD_WRITE) ? tx_byte : 8'd0;
                nxt.ack_wanted = send_ack;
            end
            else
            begin
                ignored = 1'b1;
            end
        end

        if (nxt.cmd != CMD_IDLE)
        begin
            // line levels for the slot in progress
            if (nxt.cmd == CMD_START)
            begin
                if (nxt.phase == 3'd0)
                begin
                    nxt.sda = 1'b0;
                end
                else if (nxt.phase == 3'd1)
                begin
                    nxt.scl = 1'b1;
                    nxt.sda = 1'b0;
                end
                else
                begin
                    nxt.scl = 1'b1;
                    nxt.sda = 1'b1;
                end
            end
            else if (nxt.cmd == CMD_STOP)
            begin
                if (nxt.phase == 3'd0)
                begin
                    nxt.scl = 1'b0;
                    nxt.sda = 1'b1;
                end
                else if (nxt.phase == 3'd1)
                begin
                    nxt.scl = 1'b1;
                    nxt.sda = 1'b1;
                end
                else
                begin
                    nxt.scl = 1'b1;
                    nxt.sda = 1'b0;
                end
            end
            else
            begin
                nxt.scl = nxt.phase[0];
                if (nxt.bit_idx < ACK_BIT)
                    nxt.sda = (nxt.cmd == CMD_WRITE) ? ~nxt.shift[~nxt.bit_idx[2:0]] : 1'b0;
                else
                    nxt.sda = (nxt.cmd == CMD_READ) ? nxt.ack_wanted : 1'b0;
            end

            nxt.tick = nxt.tick + HBT_W'(1);
            slot_end = nxt.tick >= slot_len;
            if (slot_end)
            begin
                nxt.tick = '0;
                if ((nxt.cmd == CMD_START) || (nxt.cmd == CMD_STOP))
                begin
                    if (nxt.phase >= PHASE_LAST_EDGE)
                        done = 1'b1;
                    else
                        nxt.phase = nxt.phase + 3'd1;
                end
                else if (nxt.phase == 3'd0)
                begin
                    nxt.phase = 3'd1;
                end
                else
                begin
                    if ((nxt.cmd == CMD_READ) && (nxt.bit_idx < ACK_BIT))
                        nxt.shift = {nxt.shift[6:0], sda_level};
                    if ((nxt.cmd == CMD_WRITE) && (nxt.bit_idx >= ACK_BIT))
                        nxt.ack_seen = ~sda_level;
                    if (nxt.bit_idx >= ACK_BIT)
                    begin
                        done = 1'b1;
                        if (nxt.cmd == CMD_READ)
                            nxt.rx_hold = nxt.shift;
                    end
                    else
                    begin
                        nxt.phase   = 3'd0;
                        nxt.bit_idx = nxt.bit_idx + 4'd1;
                    end
                end
            end
        end
        else
        begin
            slot_end = 1'b0;
        end

        res.scl_high        = nxt.scl;
        res.sda_pull_low    = nxt.sda;
        res.busy            = (nxt.cmd != CMD_IDLE);
        res.done            = done;
        res.rx_byte         = nxt.rx_hold;
        res.slave_acked     = nxt.ack_seen;
        res.command_ignored = ignored;

        // byte commands park with SCL held low and SDA released
        if (done)
        begin
            if ((nxt.cmd == CMD_WRITE) || (nxt.cmd == CMD_READ))
            begin
                nxt.scl = 1'b0;
                nxt.sda = 1'b0;
            end
            nxt.cmd     = CMD_IDLE;
            nxt.phase   = 3'd0;
            nxt.bit_idx = 4'd0;
            nxt.tick    = '0;
        end
    end

endmodule

// File: design/i2c_master_byte_engine.sv
// I2C master byte engine.
// Input channel (in_valid/in_stall): one request per line tick, carrying an
// optional command (start, stop, write byte, read byte), the byte to send,
// the ACK choice for a read and the sampled SDA level.
// Output channel (out_valid/out_stall): one result per request with the SCL
// and SDA drive levels, busy/done flags, last read byte, slave ACK and a flag
// for a command dropped while busy.
// A request accepted into the input register goes through the sequencer step
// into the result register.
// Throughput: one request per cycle while out_stall holds no result; the
// sequencer step is combinational logic from the input register to the result register.
// APB port: register 0 (address 0) is half_bit_ticks, ticks per SCL phase.
// Reset: sequencer idle, SCL released, SDA released, half_bit_ticks = 5,
// both pipeline stages empty.
// Stall: when out_stall holds a result, the input register keeps its request
// and in_stall rises in the same cycle; nothing is lost or repeated.
module i2c_master_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        sda_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_high,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        slave_acked,
    output logic        command_ignored,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    logic [HBT_W-1:0] hbt_reg;
    logic             cfg_wr;

    logic             s1_valid_reg;
    logic [2:0]       op_reg;
    logic [7:0]       tx_reg;
    logic             ack_reg;
    logic             sda_reg;

    state_t           state_reg;
    state_t           state_next;
    result_t          res_next;
    result_t          res_reg;
    logic             out_valid_reg;

    logic             advance;
    logic             in_take;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-HBT_W){1'b0}}, hbt_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hbt_reg <= HBT_RESET;
        else if (cfg_wr)
            hbt_reg <= pwdata[HBT_W-1:0];
    end

    // pipeline control
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            tx_reg  <= tx_byte;
            ack_reg <= send_ack;
            sda_reg <= sda_level;
        end
    end

    i2cm_step u_step (
        .cur            (state_reg),
        .operation      (op_reg),
        .tx_byte        (tx_reg),
        .send_ack       (ack_reg),
        .sda_level      (sda_reg),
        .half_bit_ticks (hbt_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign scl_high        = res_reg.scl_high;
    assign sda_pull_low    = res_reg.sda_pull_low;
    assign busy_res        = res_reg.busy;
    assign done_res        = res_reg.done;
    assign rx_byte         = res_reg.rx_byte;
    assign slave_acked     = res_reg.slave_acked;
    assign command_ignored = res_reg.command_ignored;

`ifndef SYNTH
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done without busy");

    a_ignored_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_ignored |-> busy_res)
        else $error("command dropped while idle");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with output free");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.done |=> (state_reg.cmd == CMD_IDLE))
        else $error("sequencer not idle after done");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // spare operation codes, treated as plain ticks
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [2:0] HBT_ADDR   = 3'd0;
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = CMD_IDLE;
    logic [7:0]  tx_byte = 8'd0;
    logic        send_ack = 1'b0;
    logic        sda_level = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_high;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        slave_acked;
    logic        command_ignored;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = HBT_ADDR;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_byte_engine u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .tx_byte         (tx_byte),
        .send_ack        (send_ack),
        .sda_level       (sda_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .scl_high        (scl_high),
        .sda_pull_low    (sda_pull_low),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .rx_byte         (rx_byte),
        .slave_acked     (slave_acked),
        .command_ignored (command_ignored),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // line sequencer mirror
    state_t           bus_seq = STATE_RESET;
    logic [HBT_W-1:0] half_bit = HBT_RESET;
    result_t          line_results_due[$];
    result_t          line_want;

    int errors = 0;
    int cycle_count = 0;
    int ticks_sent = 0;
    int burst_left = 0;
    int stall_run = 0;
    int stall_mode = 0;

    function automatic result_t step_lines(logic [2:0] op, logic [7:0] tx,
                                           logic ack_in, logic sda_in);
        result_t          r;
        logic [HBT_W-1:0] slot_len;
        logic             ignored;
        logic             done;
        logic             busy;
        ignored = 1'b0;
        done = 1'b0;
        busy = 1'b0;
        slot_len = (half_bit == '0) ? HBT_W'(1) : half_bit;

        if (op >= CMD_START && op <= CMD_READ)
        begin
            if (bus_seq.cmd == CMD_IDLE)
            begin
                bus_seq.cmd = op;
                bus_seq.phase = 3'd0;
                bus_seq.bit_idx = 4'd0;
                bus_seq.tick = '0;
                bus_seq.shift = (op == CMD_WRITE) ? tx : 8'd0;
                bus_seq.ack_wanted = ack_in;
            end
            else
            begin
                ignored = 1'b1;
            end
        end

        if (bus_seq.cmd != CMD_IDLE)
        begin
            busy = 1'b1;
            if (bus_seq.cmd == CMD_START)
            begin
                // first slot keeps SCL where it was
                if (bus_seq.phase == 3'd0)
                begin
                    bus_seq.sda = 1'b0;
                end
                else
                begin
                    bus_seq.scl = 1'b1;
                    bus_seq.sda = (bus_seq.phase != 3'd1);
                end
            end
            else if (bus_seq.cmd == CMD_STOP)
            begin
                bus_seq.scl = (bus_seq.phase != 3'd0);
                bus_seq.sda = (bus_seq.phase < PHASE_LAST_EDGE);
            end
            else
            begin
                bus_seq.scl = bus_seq.phase[0];
                if (bus_seq.bit_idx < ACK_BIT)
                    bus_seq.sda = (bus_seq.cmd == CMD_WRITE) &&
                                  !bus_seq.shift[3'd7 - bus_seq.bit_idx[2:0]];
                else
                    bus_seq.sda = (bus_seq.cmd == CMD_READ) && bus_seq.ack_wanted;
            end

            bus_seq.tick = bus_seq.tick + 1'b1;
            if (bus_seq.tick >= slot_len)
            begin
                bus_seq.tick = '0;
                if (bus_seq.cmd == CMD_START || bus_seq.cmd == CMD_STOP)
                begin
                    if (bus_seq.phase >= PHASE_LAST_EDGE)
                        done = 1'b1;
                    else
                        bus_seq.phase = bus_seq.phase + 1'b1;
                end
                else if (bus_seq.phase == 3'd0)
                begin
                    bus_seq.phase = 3'd1;
                end
                else
                begin
                    if (bus_seq.cmd == CMD_READ && bus_seq.bit_idx < ACK_BIT)
                        bus_seq.shift = {bus_seq.shift[6:0], sda_in};
                    if (bus_seq.cmd == CMD_WRITE && bus_seq.bit_idx >= ACK_BIT)
                        bus_seq.ack_seen = !sda_in;
                    if (bus_seq.bit_idx >= ACK_BIT)
                    begin
                        done = 1'b1;
                        if (bus_seq.cmd == CMD_READ)
                            bus_seq.rx_hold = bus_seq.shift;
                    end
                    else
                    begin
                        bus_seq.phase = 3'd0;
                        bus_seq.bit_idx = bus_seq.bit_idx + 1'b1;
                    end
                end
            end
        end

        r.scl_high = bus_seq.scl;
        r.sda_pull_low = bus_seq.sda;
        r.busy = busy;
        r.done = done;
        r.rx_byte = bus_seq.rx_hold;
        r.slave_acked = bus_seq.ack_seen;
        r.command_ignored = ignored;

        if (done)
        begin
            // byte commands park with SCL low and SDA released
            if (bus_seq.cmd == CMD_WRITE || bus_seq.cmd == CMD_READ)
            begin
                bus_seq.scl = 1'b0;
                bus_seq.sda = 1'b0;
            end
            bus_seq.cmd = CMD_IDLE;
            bus_seq.phase = 3'd0;
            bus_seq.bit_idx = 4'd0;
            bus_seq.tick = '0;
        end
        return r;
    endfunction

    // one tick request; the payload holds until accepted
    task automatic send_tick(logic [2:0] op, logic [7:0] tx, logic ack_in, logic sda_in);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(32, 1);
            gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        tx_byte <= tx;
        send_ack <= ack_in;
        sda_level <= sda_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
        line_results_due.push_back(step_lines(op, tx, ack_in, sda_in));
    endtask

    // issue a command and tick until the sequencer is idle again, acting as the slave
    task automatic run_command(logic [2:0] op, logic [7:0] tx, logic ack_in,
                               logic [7:0] slave_data, logic slave_ack, int noise_pct);
        logic [2:0] filler;
        logic       sda_in;
        send_tick(op, tx, ack_in, 1'($urandom));
        while (bus_seq.cmd != CMD_IDLE)
        begin
            if (bus_seq.cmd == CMD_READ && bus_seq.bit_idx < ACK_BIT)
                sda_in = slave_data[3'd7 - bus_seq.bit_idx[2:0]];
            else if (bus_seq.cmd == CMD_WRITE && bus_seq.bit_idx == ACK_BIT)
                sda_in = !slave_ack;
            else
                sda_in = 1'($urandom);
            filler = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7, 1)) : CMD_IDLE;
            send_tick(filler, 8'($urandom), 1'($urandom), sda_in);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (line_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write, then read back the slot length
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == HBT_ADDR)
            half_bit = value[HBT_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HBT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[HBT_W-1:0] !== half_bit)
        begin
            $display("%0t: half_bit_ticks readback expected %0h got %0h",
                     $time, half_bit, prdata[HBT_W-1:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_traffic(int budget);
        int         stop_at;
        int         n;
        logic [2:0] op;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
            begin
                run_command(CMD_START, 8'($urandom), 1'($urandom), 8'($urandom),
                            1'($urandom), 10);
                n = $urandom_range(3, 1);
                repeat (n)
                begin
                    op = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                    run_command(op, 8'($urandom), 1'($urandom), 8'($urandom),
                                1'($urandom), 10);
                end
                run_command(CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom),
                            1'($urandom), 10);
            end
            else
            begin
                // loose requests: stray commands, spare codes, idle ticks
                n = $urandom_range(4, 1);
                repeat (n)
                    send_tick(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_reset_rate();
        repeat (3)
            send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        run_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b1, 0);
        run_command(CMD_WRITE, 8'h96, 1'b0, 8'h00, 1'b1, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        random_traffic(80);
    endtask

    task automatic test_directed();
        logic [2:0] op;
        write_reg(HBT_ADDR, 32'd1);
        run_command(CMD_START, 8'hFF, 1'b1, 8'h00, 1'b0, 0);
        run_command(CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b1, 0);
        run_command(CMD_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b0, 0);
        run_command(CMD_WRITE, 8'h5A, 1'b0, 8'h00, 1'b1, 0);
        run_command(CMD_READ, 8'h00, 1'b1, 8'hC3, 1'b0, 0);
        run_command(CMD_READ, 8'hFF, 1'b0, 8'h3C, 1'b1, 0);
        run_command(CMD_READ, 8'h00, 1'b1, 8'h00, 1'b0, 0);
        run_command(CMD_READ, 8'h00, 1'b0, 8'hFF, 1'b0, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 0);
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op != 3'd0; op++)
            send_tick(op, 8'($urandom), 1'($urandom), 1'($urandom));
        // heavy stream of commands while busy: all must be dropped
        run_command(CMD_WRITE, 8'h81, 1'b1, 8'h00, 1'b1, 60);
        run_command(CMD_READ, 8'h00, 1'b1, 8'hA5, 1'b0, 60);
        run_command(CMD_STOP, 8'h00, 1'b1, 8'h00, 1'b0, 60);
    endtask

    task automatic test_zero_slot();
        write_reg(HBT_ADDR, 32'd0);
        random_traffic(120);
    endtask

    task automatic test_wide_writes();
        // bits above the field are dropped; a spare address changes nothing
        write_reg(HBT_ADDR, 32'hFFFF_FC02);
        write_reg(SPARE_ADDR, $urandom);
        random_traffic(120);
    endtask

    task automatic test_long_slot();
        // widest slot holds a start in its first slot; a shorter slot then ends it
        write_reg(HBT_ADDR, 32'd1023);
        send_tick(CMD_START, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (60)
            send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        write_reg(HBT_ADDR, 32'd4);
        while (bus_seq.cmd != CMD_IDLE)
            send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random_rates();
        repeat (3)
        begin
            write_reg(HBT_ADDR, $urandom_range(6, 3));
            random_traffic(50);
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_results_due.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end
            else
            begin
                line_want = line_results_due.pop_front();
                check_field("scl_high", 8'(line_want.scl_high), 8'(scl_high));
                check_field("sda_pull_low", 8'(line_want.sda_pull_low), 8'(sda_pull_low));
                check_field("busy_res", 8'(line_want.busy), 8'(busy_res));
                check_field("done_res", 8'(line_want.done), 8'(done_res));
                check_field("rx_byte", line_want.rx_byte, rx_byte);
                check_field("slave_acked", 8'(line_want.slave_acked), 8'(slave_acked));
                check_field("command_ignored", 8'(line_want.command_ignored),
                            8'(command_ignored));
            end
        end
    end

    // receiver stall pattern: runs of no stall, light and heavy back-pressure
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run <= $urandom_range(64, 1);
            stall_mode <= $urandom_range(2);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(1));
            default: out_stall <= ($urandom_range(3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_rate();
        test_directed();
        test_zero_slot();
        test_wide_writes();
        test_long_slot();
        test_random_rates();
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
design/i2cm_pkg.sv
design/i2cm_step.sv
design/i2c_master_byte_engine.sv
tb/sv/testbench.sv
